/* rtl/mexp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants for the modular exponentiation block: payload
// structs, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package mexp_pkg;

   localparam int OPERAND_WIDTH = 32;
   localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);

   typedef struct packed {
      logic [OPERAND_WIDTH-1:0] base;
      logic [OPERAND_WIDTH-1:0] exponent;
      logic [OPERAND_WIDTH-1:0] modulus;
   } req_type;

   typedef struct packed {
      logic [OPERAND_WIDTH-1:0] power_residue;
      logic                     zero_modulus;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_LOAD_BASE,
      ST_SQ_START,
      ST_SQUARE,
      ST_SQ_END,
      ST_MUL_START,
      ST_MULT,
      ST_MUL_END,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic reduce_step;
      logic base_take;
      logic mul_start;
      logic mul_by_base;
      logic mul_step;
      logic acc_take;
      logic exp_shift;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic mod_zero;
      logic step_last;
      logic exp_last;
      logic exp_bit;
   } status_type;

endpackage
`default_nettype wire

/* rtl/mexp_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_datapath
// Operand registers, exponent shifter, shift-subtract base reduction and an
// interleaved modular multiplier that handles one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mexp_datapath (
   input  wire                  clock,
   input  wire                  reset,
   input  mexp_pkg::cmd_type    cmd,
   input  mexp_pkg::req_type    req_data,
   output mexp_pkg::status_type status,
   output mexp_pkg::rsp_type    rsp_data
);
   import mexp_pkg::*;

   localparam int W = OPERAND_WIDTH;

   logic [W-1:0]         mod_ff;
   logic [W-1:0]         base_ff;
   logic [W-1:0]         exp_ff;
   logic [W-1:0]         opx_ff;
   logic [W-1:0]         opy_ff;
   logic [W-1:0]         r_ff;
   logic [W-1:0]         acc_ff;
   logic                 zero_ff;
   logic [CNT_WIDTH-1:0] cnt_ff;
   logic [CNT_WIDTH-1:0] exp_cnt_ff;
   rsp_type              rsp_ff;

   logic [W:0]   red_t;
   logic [W-1:0] red_in;
   logic [W+1:0] mul_t;
   logic [W+1:0] mod1;
   logic [W+1:0] mod2;
   logic [W+1:0] mul_wide;
   logic [W-1:0] mul_in;

   // remainder step: shift in one base bit, subtract modulus once
   always_comb begin
      red_t = {r_ff, opy_ff[W-1]};
      if (red_t >= {1'b0, mod_ff}) begin
         red_in = W'(red_t - {1'b0, mod_ff});
      end else begin
         red_in = red_t[W-1:0];
      end
   end

   // multiply step: r = 2r + bit*x, then bring below the modulus
   always_comb begin
      mod1  = {2'b00, mod_ff};
      mod2  = {1'b0, mod_ff, 1'b0};
      mul_t = {1'b0, r_ff, 1'b0} + (opy_ff[W-1] ? {2'b00, opx_ff} : '0);
      if (mul_t >= mod2) begin
         mul_wide = mul_t - mod2;
      end else if (mul_t >= mod1) begin
         mul_wide = mul_t - mod1;
      end else begin
         mul_wide = mul_t;
      end
      mul_in = mul_wide[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mod_ff  <= req_data.modulus;
         zero_ff <= (req_data.modulus == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         exp_ff     <= req_data.exponent;
         exp_cnt_ff <= CNT_WIDTH'(W - 1);
      end else if (cmd.exp_shift) begin
         exp_ff     <= {exp_ff[W-2:0], 1'b0};
         exp_cnt_ff <= exp_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         opy_ff <= req_data.base;
         r_ff   <= '0;
         cnt_ff <= CNT_WIDTH'(W - 1);
      end else if (cmd.reduce_step) begin
         opy_ff <= {opy_ff[W-2:0], 1'b0};
         r_ff   <= red_in;
         cnt_ff <= cnt_ff - 1'b1;
      end else if (cmd.mul_start) begin
         opx_ff <= acc_ff;
         opy_ff <= cmd.mul_by_base ? base_ff : acc_ff;
         r_ff   <= '0;
         cnt_ff <= CNT_WIDTH'(W - 1);
      end else if (cmd.mul_step) begin
         opy_ff <= {opy_ff[W-2:0], 1'b0};
         r_ff   <= mul_in;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.base_take) begin
         base_ff <= r_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (req_data.modulus == W'(0) || req_data.modulus == W'(1)) begin
            acc_ff <= '0;
         end else begin
            acc_ff <= W'(1);
         end
      end else if (cmd.acc_take) begin
         acc_ff <= r_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.power_residue <= acc_ff;
         rsp_ff.zero_modulus  <= zero_ff;
      end
   end

   assign status.mod_zero  = (req_data.modulus == '0);
   assign status.step_last = (cnt_ff == '0);
   assign status.exp_last  = (exp_cnt_ff == '0);
   assign status.exp_bit   = exp_ff[W-1];
   assign rsp_data         = rsp_ff;

`ifndef SYNTHESIS
   a_mul_rem_below_mod: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_step |-> r_ff < mod_ff)
      else $error("multiplier partial result not below modulus");

   a_acc_below_mod: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> (acc_ff < mod_ff) && (base_ff < mod_ff || !cmd.mul_by_base))
      else $error("multiplier operand not reduced");

   a_reduce_below_mod: assert property (@(posedge clock) disable iff (reset)
      cmd.base_take |-> r_ff < mod_ff)
      else $error("reduced base not below modulus");
`endif

endmodule
`default_nettype wire

/* rtl/mexp_controller.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_controller
// Sequencer for base reduction and the square-and-multiply loop; owns the
// request/response handshake.
// ----------------------------------------------------------------------------
module mexp_controller (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   input  mexp_pkg::status_type status,
   output mexp_pkg::cmd_type    cmd
);
   import mexp_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.mod_zero ? ST_FINISH : ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.reduce_step = 1'b1;
            if (status.step_last) begin
               state_in = ST_LOAD_BASE;
            end
         end
         ST_LOAD_BASE: begin
            cmd.base_take = 1'b1;
            state_in      = ST_SQ_START;
         end
         ST_SQ_START: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.mul_step = 1'b1;
            if (status.step_last) begin
               state_in = ST_SQ_END;
            end
         end
         ST_SQ_END: begin
            cmd.acc_take = 1'b1;
            if (status.exp_bit) begin
               state_in = ST_MUL_START;
            end else if (status.exp_last) begin
               state_in = ST_FINISH;
            end else begin
               cmd.exp_shift = 1'b1;
               state_in      = ST_SQ_START;
            end
         end
         ST_MUL_START: begin
            cmd.mul_start   = 1'b1;
            cmd.mul_by_base = 1'b1;
            state_in        = ST_MULT;
         end
         ST_MULT: begin
            cmd.mul_step = 1'b1;
            if (status.step_last) begin
               state_in = ST_MUL_END;
            end
         end
         ST_MUL_END: begin
            cmd.acc_take = 1'b1;
            if (status.exp_last) begin
               state_in = ST_FINISH;
            end else begin
               cmd.exp_shift = 1'b1;
               state_in      = ST_SQ_START;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff != ST_IDLE)
      else $error("transaction accepted but controller stayed idle");

   a_finish_posts_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished transaction not posted");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending response overwritten");
`endif

endmodule
`default_nettype wire

/* rtl/modular_exponentiation.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base^exponent mod modulus with left-to-right square-and-multiply.
// ----------------------------------------------------------------------------
// One transaction at a time. The base is first reduced by a shift-subtract
// remainder. Each of the 32 exponent bits, scanned from bit 31 down, costs
// one modular square and, for a set bit, one modular multiply by the base.
// The modular multiplier works one multiplier bit per cycle and sets the rate.
// A zero modulus returns 0 with zero_modulus set, once the output register
// is free. The response sits in an output register, so a new request is
// taken while the previous response waits.
// ----------------------------------------------------------------------------
module modular_exponentiation (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  mexp_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output mexp_pkg::rsp_type  rsp_data
);
   import mexp_pkg::*;

   cmd_type    cmd;
   status_type status;

   mexp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mexp_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire
